// ===== sv/touch_point_calibrate_top_defines.svh =====
// Assertion macros for the checker of the touch calibration block.
`ifndef TOUCH_POINT_CALIBRATE_TOP_DEFINES_SVH
`define TOUCH_POINT_CALIBRATE_TOP_DEFINES_SVH

// Check cons in the same cycle as ante.
`define TPC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("touch calibrate check failed");

// Check cons a fixed number of cycles after ante.
`define TPC_ASSERT_LATER(label, clk, rst, ante, n, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error("touch calibrate latency check failed");

`endif

// ===== sv/tpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tpc_pkg;

   localparam int SCREEN_W  = 320;
   localparam int SCREEN_H  = 240;
   localparam int LANES     = 2;   // lane 0 is x, lane 1 is y
   localparam int RAW_W     = 16;
   localparam int DIFF_W    = 20;  // offset from the low border, signed
   localparam int SPAN_W    = 18;  // border span, signed
   localparam int MAG_W     = 17;  // magnitudes once the quotient is known to stay below size
   localparam int QW        = 9;   // quotient bits
   localparam int NUM_W     = MAG_W + QW;
   localparam int STEP_BITS = 3;
   localparam int STEPS     = QW / STEP_BITS;
   localparam int PIPE_DEPTH = 4 + STEPS; // register stages from accept to result

   localparam logic [7:0] STATUS_READY_MASK = 8'h80;
   localparam logic [7:0] STATUS_COUNT_MASK = 8'h0F;

   localparam logic [QW-1:0] SCREEN_SIZE [LANES] = '{QW'(SCREEN_W), QW'(SCREEN_H)};

   typedef enum logic [1:0] {
      CSR_X_LOW  = 2'd0,
      CSR_Y_LOW  = 2'd1,
      CSR_X_HIGH = 2'd2,
      CSR_Y_HIGH = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic valid;
      logic touched;
      logic clear;
   } beat_ctl_type;

endpackage

`default_nettype wire

// ===== sv/touch_point_calibrate_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Touch point calibration: one controller poll in, one screen point out.
// Request: a beat is taken at each rising edge with start high and busy low.
// busy stays low, so a new poll may be issued in every cycle.
// Fields: bus_ok, status byte, raw x and raw y of the first point.
// Response: rsp_valid strobes for one cycle with touched, screen_x (0..319),
// screen_y (0..239) and clear_status. Results come back in request order.
// Path: stage 1, stage 2, stage 3, the division stages, then the output stage.
// Throughput: one beat per cycle. Each axis runs a pipelined restoring divider,
// three quotient bits per stage over three stages; the subtract/compare chain
// of one stage sets the clock.
// Configuration: csr_we writes csr_wdata into register csr_index (x low, y low,
// x high, y high) at once. Write only when no beat is in flight.
// Reset (synchronous, active high) restores the borders 0/0/320/240 and drops
// every beat still in flight. The receiver cannot stall: each strobe is taken
// in the cycle it shows.
module touch_point_calibrate_top
   import tpc_pkg::*;
#(
   parameter int PANEL_HEIGHT = 240
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start,
   output logic                    busy,
   input  wire                     req_bus_ok,
   input  wire  [7:0]              req_status_byte,
   input  wire  [RAW_W-1:0]        req_raw_x,
   input  wire  [RAW_W-1:0]        req_raw_y,
   output logic                    rsp_valid,
   output logic                    rsp_touched,
   output logic [8:0]              rsp_screen_x,
   output logic [7:0]              rsp_screen_y,
   output logic                    rsp_clear_status,
   input  wire                     csr_we,
   input  wire  [1:0]              csr_index,
   input  wire  [RAW_W-1:0]        csr_wdata
);

   // Calibration borders.
   logic signed [RAW_W-1:0] x_low_ff, y_low_ff, x_high_ff, y_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_low_ff  <= '0;
         y_low_ff  <= '0;
         x_high_ff <= RAW_W'(SCREEN_W);
         y_high_ff <= RAW_W'(SCREEN_H);
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_X_LOW:  x_low_ff  <= csr_wdata;
            CSR_Y_LOW:  y_low_ff  <= csr_wdata;
            CSR_X_HIGH: x_high_ff <= csr_wdata;
            CSR_Y_HIGH: y_high_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // No stall anywhere: the pipeline takes a beat every cycle.
   assign busy = 1'b0;

   // ---------------------------------------------------------------------
   // Stage 1: decode status, flip y, form offset and span per axis.
   // ---------------------------------------------------------------------
   beat_ctl_type            s1_ctl_in, s1_ctl_ff;
   logic [DIFF_W-1:0]       s1_diff_in [LANES];
   logic [DIFF_W-1:0]       s1_diff_ff [LANES];
   logic [SPAN_W-1:0]       s1_span_in [LANES];
   logic [SPAN_W-1:0]       s1_span_ff [LANES];
   logic [DIFF_W-1:0]       flip_y;

   always_comb begin
      s1_ctl_in.valid   = start && !busy;
      s1_ctl_in.clear   = req_bus_ok;
      s1_ctl_in.touched = req_bus_ok && ((req_status_byte & STATUS_READY_MASK) != '0)
                          && ((req_status_byte & STATUS_COUNT_MASK) != '0);

      // Flip y about the panel height.
      flip_y = DIFF_W'(PANEL_HEIGHT - 1) - DIFF_W'(req_raw_y);

      s1_diff_in[0] = DIFF_W'(req_raw_x) - DIFF_W'(x_low_ff);
      s1_diff_in[1] = flip_y - DIFF_W'(y_low_ff);
      s1_span_in[0] = SPAN_W'(x_high_ff) - SPAN_W'(x_low_ff);
      s1_span_in[1] = SPAN_W'(y_high_ff) - SPAN_W'(y_low_ff);
   end

   // ---------------------------------------------------------------------
   // Stage 2: magnitudes and the two early outcomes. Zero span or a quotient
   // that is negative or truncates to zero gives 0; |offset| >= |span| means
   // the quotient reaches the screen size, so clamp to the far edge.
   // ---------------------------------------------------------------------
   beat_ctl_type            s2_ctl_ff;
   logic                    s2_zero_in [LANES];
   logic                    s2_zero_ff [LANES];
   logic                    s2_sat_in  [LANES];
   logic                    s2_sat_ff  [LANES];
   logic [MAG_W-1:0]        s2_mag_in  [LANES];
   logic [MAG_W-1:0]        s2_mag_ff  [LANES];
   logic [MAG_W-1:0]        s2_div_in  [LANES];
   logic [MAG_W-1:0]        s2_div_ff  [LANES];

   always_comb begin
      logic [DIFF_W-1:0] abs_diff;
      logic [SPAN_W-1:0] abs_span;
      for (int l = 0; l < LANES; l++) begin
         abs_diff = s1_diff_ff[l][DIFF_W-1] ? (DIFF_W'(0) - s1_diff_ff[l]) : s1_diff_ff[l];
         abs_span = s1_span_ff[l][SPAN_W-1] ? (SPAN_W'(0) - s1_span_ff[l]) : s1_span_ff[l];
         s2_zero_in[l] = (s1_span_ff[l] == '0) || (s1_diff_ff[l] == '0)
                         || (s1_diff_ff[l][DIFF_W-1] != s1_span_ff[l][SPAN_W-1]);
         s2_sat_in[l]  = abs_diff >= DIFF_W'(abs_span);
         s2_mag_in[l]  = abs_diff[MAG_W-1:0];
         s2_div_in[l]  = abs_span[MAG_W-1:0];
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: scale the offset magnitude by the screen size.
   // ---------------------------------------------------------------------
   beat_ctl_type            s3_ctl_ff;
   logic                    s3_zero_ff [LANES];
   logic                    s3_sat_ff  [LANES];
   logic [NUM_W-1:0]        s3_num_ff  [LANES];
   logic [MAG_W-1:0]        s3_div_ff  [LANES];

   // ---------------------------------------------------------------------
   // Division stages: restoring long division, STEP_BITS quotient bits each.
   // The quotient is known to fit QW bits, so the partial remainder starts
   // at the numerator's upper part and stays below the divisor.
   // ---------------------------------------------------------------------
   beat_ctl_type            dv_ctl_ff  [STEPS];
   logic                    dv_zero_ff [STEPS][LANES];
   logic                    dv_sat_ff  [STEPS][LANES];
   logic [QW-1:0]           dv_low_ff  [STEPS][LANES];
   logic [MAG_W-1:0]        dv_div_ff  [STEPS][LANES];
   logic [MAG_W-1:0]        dv_rem_in  [STEPS][LANES];
   logic [MAG_W-1:0]        dv_rem_ff  [STEPS][LANES];
   logic [QW-1:0]           dv_quo_in  [STEPS][LANES];
   logic [QW-1:0]           dv_quo_ff  [STEPS][LANES];

   always_comb begin
      logic [MAG_W:0]   trial;
      logic [MAG_W-1:0] rem;
      logic [QW-1:0]    quo;
      logic [QW-1:0]    low;
      logic [MAG_W-1:0] dvs;
      for (int j = 0; j < STEPS; j++) begin
         for (int l = 0; l < LANES; l++) begin
            if (j == 0) begin
               rem = s3_num_ff[l][NUM_W-1:QW];
               quo = '0;
               low = s3_num_ff[l][QW-1:0];
               dvs = s3_div_ff[l];
            end else begin
               rem = dv_rem_ff[j-1][l];
               quo = dv_quo_ff[j-1][l];
               low = dv_low_ff[j-1][l];
               dvs = dv_div_ff[j-1][l];
            end
            for (int k = 0; k < STEP_BITS; k++) begin
               trial = {rem, low[QW-1-STEP_BITS*j-k]};
               if (trial >= {1'b0, dvs}) begin
                  rem = MAG_W'(trial - {1'b0, dvs});
                  quo[QW-1-STEP_BITS*j-k] = 1'b1;
               end else begin
                  rem = trial[MAG_W-1:0];
               end
            end
            dv_rem_in[j][l] = rem;
            dv_quo_in[j][l] = quo;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Output stage: pick zero, far edge or quotient.
   // ---------------------------------------------------------------------
   logic                    out_valid_ff;
   logic                    out_touched_ff, out_clear_ff;
   logic [QW-1:0]           out_pos_in [LANES];
   logic [QW-1:0]           out_pos_ff [LANES];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if (!dv_ctl_ff[STEPS-1].touched || dv_zero_ff[STEPS-1][l]) begin
            out_pos_in[l] = '0;
         end else if (dv_sat_ff[STEPS-1][l]) begin
            out_pos_in[l] = SCREEN_SIZE[l] - QW'(1);
         end else begin
            out_pos_in[l] = dv_quo_ff[STEPS-1][l];
         end
      end
   end

   always_ff @(posedge clock) begin
      // Payload: no reset, advance every cycle.
      s1_ctl_ff.touched <= s1_ctl_in.touched;
      s1_ctl_ff.clear   <= s1_ctl_in.clear;
      s2_ctl_ff.touched <= s1_ctl_ff.touched;
      s2_ctl_ff.clear   <= s1_ctl_ff.clear;
      s3_ctl_ff.touched <= s2_ctl_ff.touched;
      s3_ctl_ff.clear   <= s2_ctl_ff.clear;
      dv_ctl_ff[0].touched <= s3_ctl_ff.touched;
      dv_ctl_ff[0].clear   <= s3_ctl_ff.clear;
      for (int j = 1; j < STEPS; j++) begin
         dv_ctl_ff[j].touched <= dv_ctl_ff[j-1].touched;
         dv_ctl_ff[j].clear   <= dv_ctl_ff[j-1].clear;
      end
      out_touched_ff <= dv_ctl_ff[STEPS-1].touched;
      out_clear_ff   <= dv_ctl_ff[STEPS-1].clear;

      for (int l = 0; l < LANES; l++) begin
         s1_diff_ff[l] <= s1_diff_in[l];
         s1_span_ff[l] <= s1_span_in[l];

         s2_zero_ff[l] <= s2_zero_in[l];
         s2_sat_ff[l]  <= s2_sat_in[l];
         s2_mag_ff[l]  <= s2_mag_in[l];
         s2_div_ff[l]  <= s2_div_in[l];

         s3_zero_ff[l] <= s2_zero_ff[l];
         s3_sat_ff[l]  <= s2_sat_ff[l];
         s3_num_ff[l]  <= NUM_W'(s2_mag_ff[l]) * NUM_W'(SCREEN_SIZE[l]);
         s3_div_ff[l]  <= s2_div_ff[l];

         dv_zero_ff[0][l] <= s3_zero_ff[l];
         dv_sat_ff[0][l]  <= s3_sat_ff[l];
         dv_low_ff[0][l]  <= s3_num_ff[l][QW-1:0];
         dv_div_ff[0][l]  <= s3_div_ff[l];
         for (int j = 1; j < STEPS; j++) begin
            dv_zero_ff[j][l] <= dv_zero_ff[j-1][l];
            dv_sat_ff[j][l]  <= dv_sat_ff[j-1][l];
            dv_low_ff[j][l]  <= dv_low_ff[j-1][l];
            dv_div_ff[j][l]  <= dv_div_ff[j-1][l];
         end
         for (int j = 0; j < STEPS; j++) begin
            dv_rem_ff[j][l] <= dv_rem_in[j][l];
            dv_quo_ff[j][l] <= dv_quo_in[j][l];
         end

         out_pos_ff[l] <= out_pos_in[l];
      end

      // Valid bits: cleared by reset, advance every cycle.
      if (reset) begin
         s1_ctl_ff.valid <= 1'b0;
         s2_ctl_ff.valid <= 1'b0;
         s3_ctl_ff.valid <= 1'b0;
         for (int j = 0; j < STEPS; j++) begin
            dv_ctl_ff[j].valid <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else begin
         s1_ctl_ff.valid <= s1_ctl_in.valid;
         s2_ctl_ff.valid <= s1_ctl_ff.valid;
         s3_ctl_ff.valid <= s2_ctl_ff.valid;
         dv_ctl_ff[0].valid <= s3_ctl_ff.valid;
         for (int j = 1; j < STEPS; j++) begin
            dv_ctl_ff[j].valid <= dv_ctl_ff[j-1].valid;
         end
         out_valid_ff <= dv_ctl_ff[STEPS-1].valid;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_touched      = out_touched_ff;
   assign rsp_clear_status = out_clear_ff;
   assign rsp_screen_x     = out_pos_ff[0];
   assign rsp_screen_y     = out_pos_ff[1][7:0];

endmodule

`default_nettype wire

// ===== sv/tpc_check.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "touch_point_calibrate_top_defines.svh"

module tpc_check
   import tpc_pkg::*;
(
   input wire              clock,
   input wire              reset,
   input wire              start,
   input wire              busy,
   input wire              req_bus_ok,
   input wire [7:0]        req_status_byte,
   input wire [RAW_W-1:0]  req_raw_x,
   input wire [RAW_W-1:0]  req_raw_y,
   input wire              rsp_valid,
   input wire              rsp_touched,
   input wire [8:0]        rsp_screen_x,
   input wire [7:0]        rsp_screen_y,
   input wire              rsp_clear_status,
   input wire              csr_we,
   input wire [1:0]        csr_index,
   input wire [RAW_W-1:0]  csr_wdata
);

   // An untouched beat carries a zero point.
   `TPC_ASSERT_IMPLY(a_idle_point_zero, clock, reset, rsp_valid && !rsp_touched, (rsp_screen_x == '0) && (rsp_screen_y == '0))

   // A touch always asks for the status clear and stays on screen.
   `TPC_ASSERT_IMPLY(a_touch_on_screen, clock, reset, rsp_valid && rsp_touched, rsp_clear_status && (rsp_screen_x <= 9'(SCREEN_W - 1)) && (rsp_screen_y <= 8'(SCREEN_H - 1)))

   // Every strobe traces back to a request beat a fixed latency earlier.
   `TPC_ASSERT_IMPLY(a_no_phantom, clock, reset, rsp_valid, $past(start && !busy, PIPE_DEPTH))

   // Every request beat comes back after the fixed latency with its bus flag.
   `TPC_ASSERT_LATER(a_beat_returns, clock, reset, start && !busy, PIPE_DEPTH, rsp_valid && (rsp_clear_status == $past(req_bus_ok, PIPE_DEPTH)))

endmodule

bind touch_point_calibrate_top tpc_check u_tpc_check (.*);

`default_nettype wire

// ===== bench/touch_point_calibrate_checker.sv =====
`timescale 1ns / 1ps

// Watches the poll and point channels and the border writes, predicts each
// screen point and checks it against the strobed beat, in order.
module touch_point_calibrate_checker
   import tpc_pkg::*;
#(
   parameter int PANEL_HEIGHT = 240
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  logic             req_bus_ok,
   input  logic [7:0]       req_status_byte,
   input  logic [RAW_W-1:0] req_raw_x,
   input  logic [RAW_W-1:0] req_raw_y,
   input  logic             rsp_valid,
   input  logic             rsp_touched,
   input  logic [8:0]       rsp_screen_x,
   input  logic [7:0]       rsp_screen_y,
   input  logic             rsp_clear_status,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [RAW_W-1:0] csr_wdata,
   output int               points_in_flight,
   output int               fail_count
);

   typedef struct packed {
      logic       touched;
      logic [8:0] screen_x;
      logic [7:0] screen_y;
      logic       clear_status;
   } screen_point_type;

   screen_point_type        pending_points[$];
   logic signed [RAW_W-1:0] x_lo, y_lo, x_hi, y_hi;

   initial begin
      points_in_flight = 0;
      fail_count       = 0;
   end

   // Map pos from [lo, hi) onto [0, size): truncate toward zero, then clamp.
   function automatic longint scale_axis(longint pos, longint lo, longint hi, longint size);
      longint span, q;
      span = hi - lo;
      if (span == 0) return 0;
      q = ((pos - lo) * size) / span;
      if (q < 0) q = 0;
      if (q > size - 1) q = size - 1;
      return q;
   endfunction

   function automatic screen_point_type calibrate_poll(logic ok, logic [7:0] status,
                                                       logic [RAW_W-1:0] rx,
                                                       logic [RAW_W-1:0] ry);
      screen_point_type pt;
      longint           flipped;
      pt = '0;
      if (!ok) return pt;
      pt.clear_status = 1'b1;
      if ((status & STATUS_READY_MASK) == 0 || (status & STATUS_COUNT_MASK) == 0) return pt;
      flipped     = longint'(PANEL_HEIGHT) - 1 - longint'(ry);
      pt.touched  = 1'b1;
      pt.screen_x = 9'(scale_axis(longint'(rx), longint'(x_lo), longint'(x_hi), SCREEN_W));
      pt.screen_y = 8'(scale_axis(flipped, longint'(y_lo), longint'(y_hi), SCREEN_H));
      return pt;
   endfunction

   function automatic int field_miss(string name, logic [8:0] want, logic [8:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      screen_point_type want;
      int               misses;
      misses = 0;
      if (reset) begin
         pending_points.delete();
         x_lo <= '0;
         y_lo <= '0;
         x_hi <= RAW_W'(SCREEN_W);
         y_hi <= RAW_W'(SCREEN_H);
      end else begin
         if (rsp_valid) begin
            if (pending_points.size() == 0) begin
               $error("point beat with none expected: touched %0b x %0d y %0d clear %0b",
                      rsp_touched, rsp_screen_x, rsp_screen_y, rsp_clear_status);
               misses++;
            end else begin
               want = pending_points.pop_front();
               misses += field_miss("touched", 9'(want.touched), 9'(rsp_touched));
               misses += field_miss("screen_x", want.screen_x, rsp_screen_x);
               misses += field_miss("screen_y", 9'(want.screen_y), 9'(rsp_screen_y));
               misses += field_miss("clear_status", 9'(want.clear_status),
                                    9'(rsp_clear_status));
            end
         end
         if (start && !busy)
            pending_points.push_back(calibrate_poll(req_bus_ok, req_status_byte,
                                                    req_raw_x, req_raw_y));
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_X_LOW:  x_lo <= csr_wdata;
               CSR_Y_LOW:  y_lo <= csr_wdata;
               CSR_X_HIGH: x_hi <= csr_wdata;
               CSR_Y_HIGH: y_hi <= csr_wdata;
               default: ;
            endcase
         end
      end
      points_in_flight <= pending_points.size();
      fail_count       <= fail_count + misses;
   end

endmodule

// ===== bench/tb_touch_point_calibrate_top.sv =====
`timescale 1ns / 1ps

// Drive polls into the calibration block, rewrite the borders between
// phases, and leave all prediction and comparison to the checker.
module tb_touch_point_calibrate_top;
   import tpc_pkg::*;

   localparam int PANEL_HEIGHT = 240;
   localparam int PHASES       = 8;
   localparam int PHASE_POLLS  = 50;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic             req_bus_ok = 1'b0;
   logic [7:0]       req_status_byte = '0;
   logic [RAW_W-1:0] req_raw_x = '0;
   logic [RAW_W-1:0] req_raw_y = '0;
   logic             rsp_valid;
   logic             rsp_touched;
   logic [8:0]       rsp_screen_x;
   logic [7:0]       rsp_screen_y;
   logic             rsp_clear_status;
   logic             csr_we = 1'b0;
   logic [1:0]       csr_index = '0;
   logic [RAW_W-1:0] csr_wdata = '0;
   int               points_in_flight;
   int               fail_count;

   // Border copy on the stimulus side, only to aim raw points near the span.
   int cfg_x_lo = 0, cfg_y_lo = 0, cfg_x_hi = SCREEN_W, cfg_y_hi = SCREEN_H;
   // Set for phases that send back to back with no idle cycles.
   bit steady = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   touch_point_calibrate_top #(
      .PANEL_HEIGHT(PANEL_HEIGHT)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_bus_ok      (req_bus_ok),
      .req_status_byte (req_status_byte),
      .req_raw_x       (req_raw_x),
      .req_raw_y       (req_raw_y),
      .rsp_valid       (rsp_valid),
      .rsp_touched     (rsp_touched),
      .rsp_screen_x    (rsp_screen_x),
      .rsp_screen_y    (rsp_screen_y),
      .rsp_clear_status(rsp_clear_status),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   touch_point_calibrate_checker #(
      .PANEL_HEIGHT(PANEL_HEIGHT)
   ) i_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_bus_ok      (req_bus_ok),
      .req_status_byte (req_status_byte),
      .req_raw_x       (req_raw_x),
      .req_raw_y       (req_raw_y),
      .rsp_valid       (rsp_valid),
      .rsp_touched     (rsp_touched),
      .rsp_screen_x    (rsp_screen_x),
      .rsp_screen_y    (rsp_screen_y),
      .rsp_clear_status(rsp_clear_status),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .points_in_flight(points_in_flight),
      .fail_count      (fail_count)
   );

   // Send one poll beat. Unless steady is set, idle a random number of cycles
   // first, then hold start high until the block takes the beat. Leave start high
   // afterward so a back-to-back beat never lowers and raises it in the same step.
   task automatic send_poll(input logic ok, input logic [7:0] status,
                            input logic [RAW_W-1:0] x, input logic [RAW_W-1:0] y);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_bus_ok      <= ok;
      req_status_byte <= status;
      req_raw_x       <= x;
      req_raw_y       <= y;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // Drop start and wait until every predicted point has come back.
   task automatic drain_points();
      start <= 1'b0;
      do @(posedge clock); while (points_in_flight != 0);
   endtask

   // Write all four borders, one register per cycle. Call only when drained.
   task automatic set_borders(input int xl, input int yl, input int xh, input int yh);
      int vals[4];
      vals = '{xl, yl, xh, yh};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= 2'(i);
         csr_wdata <= RAW_W'(vals[i]);
         @(posedge clock);
      end
      csr_we   <= 1'b0;
      cfg_x_lo = xl;
      cfg_y_lo = yl;
      cfg_x_hi = xh;
      cfg_y_hi = yh;
   endtask

   // Pick a value around the border span, 40 counts past either side.
   function automatic logic [RAW_W-1:0] pick_near(int lo, int hi);
      int a, b;
      a = ((lo < hi) ? lo : hi) - 40;
      b = ((lo < hi) ? hi : lo) + 40;
      return RAW_W'(a + $urandom_range(0, b - a));
   endfunction

   // Mostly well-formed touches aimed at the calibrated area; the rest is noise.
   task automatic send_random_poll();
      logic [7:0]       status;
      logic [RAW_W-1:0] x, y;
      if ($urandom_range(0, 9) < 7) begin
         status[7]   = 1'b1;
         status[6:4] = 3'($urandom_range(0, 7));
         status[3:0] = 4'($urandom_range(1, 15));
         x = pick_near(cfg_x_lo, cfg_x_hi);
         // Invert the panel flip so the flipped y lands near the y span.
         y = RAW_W'(PANEL_HEIGHT - 1) - pick_near(cfg_y_lo, cfg_y_hi);
         send_poll(1'b1, status, x, y);
      end else begin
         status = 8'($urandom_range(0, 255));
         x      = RAW_W'($urandom_range(0, 65535));
         y      = RAW_W'($urandom_range(0, 65535));
         send_poll(1'($urandom_range(0, 1)), status, x, y);
      end
   endtask

   initial begin
      int lo, hi;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset borders: identity map on x, flipped identity on y.
      send_poll(1'b0, 8'hFF, 16'd100, 16'd100);      // bus failure masks a good status
      send_poll(1'b1, 8'h00, 16'd100, 16'd100);      // not ready, no points
      send_poll(1'b1, 8'h80, 16'd100, 16'd100);      // ready but zero points
      send_poll(1'b1, 8'h0F, 16'd100, 16'd100);      // points but not ready
      send_poll(1'b1, 8'h81, 16'd0, 16'd0);          // corner, y flips to last row
      send_poll(1'b1, 8'hFF, 16'hFFFF, 16'hFFFF);    // far x clamps, flipped y goes negative
      send_poll(1'b1, 8'h85, 16'd319, 16'd239);      // last column, flipped y at row 0
      send_poll(1'b1, 8'hF1, 16'd320, 16'd240);      // x just past the span
      send_poll(1'b1, 8'h8A, 16'd160, 16'd120);
      drain_points();

      // Widest span on x, widest reversed span on y.
      set_borders(-32768, 32767, 32767, -32768);
      send_poll(1'b1, 8'h81, 16'd0, 16'd0);
      send_poll(1'b1, 8'h81, 16'hFFFF, 16'hFFFF);
      send_poll(1'b1, 8'h81, 16'h8000, 16'h7FFF);
      send_poll(1'b1, 8'h81, 16'h7FFF, 16'h8000);
      drain_points();

      // Zero span on x only, short reversed span on y.
      set_borders(100, 300, 100, 50);
      send_poll(1'b1, 8'h83, 16'd100, 16'd0);
      send_poll(1'b1, 8'h83, 16'd5000, 16'd100);
      send_poll(1'b1, 8'h83, 16'd0, 16'hFFFF);
      drain_points();

      // Random phases, each on its own border setting.
      for (int p = 0; p < PHASES; p++) begin
         steady = (p % 3 == 2);
         case (p)
            0: set_borders($urandom_range(0, 400), $urandom_range(0, 400),
                           $urandom_range(3500, 4095), $urandom_range(3500, 4095));
            1: set_borders(32767, -32768, -32768, 32767);
            2: begin
               lo = $urandom_range(0, 65535) - 32768;
               hi = $urandom_range(0, 65535) - 32768;
               set_borders(lo, hi, lo, hi);
            end
            3: set_borders($urandom_range(3500, 4095), $urandom_range(3500, 4095),
                           $urandom_range(0, 400), $urandom_range(0, 400));
            5: begin
               lo = $urandom_range(0, 2000) - 1000;
               set_borders(lo, lo + 3, lo + $urandom_range(1, 5), lo + 3 + $urandom_range(1, 5));
            end
            6: set_borders(0, 0, SCREEN_W, SCREEN_H);
            default: set_borders($urandom_range(0, 65535) - 32768,
                                 $urandom_range(0, 65535) - 32768,
                                 $urandom_range(0, 65535) - 32768,
                                 $urandom_range(0, 65535) - 32768);
         endcase
         for (int n = 0; n < PHASE_POLLS; n++) begin
            // Hold off mid-phase in odd phases until the pipe is empty.
            if (p % 2 == 1 && n == PHASE_POLLS / 2) drain_points();
            send_random_poll();
         end
         drain_points();
      end

      // Allow stray beats time to show past the pipe depth.
      repeat (PIPE_DEPTH + 4) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #(2_000_000);
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== touch_point_calibrate_top.f =====
+incdir+sv
sv/tpc_pkg.sv
sv/touch_point_calibrate_top.sv
sv/tpc_check.sv
bench/touch_point_calibrate_checker.sv
bench/tb_touch_point_calibrate_top.sv
